/* rtl/core/wcle_pkg.sv */
// Shared constants, types and CRC function for the credential length encoder.
package wcle_pkg;

   // Buffer geometry
   localparam int MAX_BYTES = 128;
   localparam int GROUPS    = (MAX_BYTES + 3) / 4;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int GROUP_W   = ADDR_W - 2;
   localparam int COUNT_W   = $clog2(MAX_BYTES + 1);

   // Request function codes
   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_FETCH  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic append;
      logic clear;
      logic fetch;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rsp_free;
   } stat_type;

   // CRC-8 Dallas/Maxim of one byte, init zero
   function automatic logic [7:0] crc8_byte(input logic [7:0] a);
      logic [7:0] c;
      logic [7:0] d;
      c = 8'h00;
      d = a;
      for (int k = 0; k < 8; k++) begin
         if ((c[0] ^ d[0]) == 1'b1) begin
            c = ((c ^ 8'h18) >> 1) | 8'h80;
         end else begin
            c = c >> 1;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

/* rtl/core/wcle_ctrl.sv */
// Controller state machine: request handshake and command sequencing.
module wcle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  wcle_pkg::stat_type stat,
   output wcle_pkg::cmd_type  cmd
);
   import wcle_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_APPEND = 2'd1;
   localparam logic [1:0] ST_FETCH  = 2'd2;
   localparam logic [1:0] ST_CLEAR  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Decode the accepted transaction into an execute state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_APPEND: state_in = ST_APPEND;
                  FUNC_FETCH:  state_in = ST_FETCH;
                  FUNC_CLEAR:  state_in = ST_CLEAR;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_APPEND: state_in = ST_IDLE;
         ST_CLEAR:  state_in = ST_IDLE;
         ST_FETCH: begin
            // hold until the response register can take the symbol
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Issue datapath commands
   always_comb begin
      cmd.capture = accept;
      cmd.append  = (state_ff == ST_APPEND);
      cmd.clear   = (state_ff == ST_CLEAR);
      cmd.fetch   = (state_ff == ST_FETCH) && stat.rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/wcle_dpath.sv */
// Datapath: byte and checksum stores, frame pointer and response register.
module wcle_dpath (
   input  logic              clock,
   input  logic              reset,
   input  wcle_pkg::cmd_type  cmd,
   output wcle_pkg::stat_type stat,
   input  logic [7:0]        req_data_byte,
   input  logic              csr_wr_en,
   input  logic [6:0]        csr_wr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [8:0]        rsp_symbol,
   output logic              rsp_frame_end,
   output logic [1:0]        rsp_status
);
   import wcle_pkg::*;

   localparam logic [1:0] PHASE_MAGIC  = 2'd0;
   localparam logic [1:0] PHASE_PREFIX = 2'd1;
   localparam logic [1:0] PHASE_GROUPS = 2'd2;

   // Storage
   logic [7:0]         byte_mem [MAX_BYTES];
   logic [7:0]         gc_mem [GROUPS];
   logic [7:0]         byte_rd_ff;
   logic [7:0]         gc_rd_ff;

   // Registers
   logic [7:0]         data_byte_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         ssid_ff, ssid_in;
   logic               overflow_ff, overflow_in;
   logic [1:0]         phase_ff, phase_in;
   logic [GROUP_W-1:0] group_ff, group_in;
   logic [2:0]         slot_ff, slot_in;
   logic [6:0]         pass_len_ff;
   logic [7:0]         gc_run_ff;
   logic               rsp_valid_ff;
   logic [8:0]         rsp_symbol_ff, rsp_symbol_in;
   logic               rsp_frame_end_ff, rsp_frame_end_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   // Append path
   logic               full;
   logic [ADDR_W-1:0]  pos;
   logic [GROUP_W-1:0] app_group;
   logic [7:0]         seed;
   logic [7:0]         gc_new;
   logic               ssid_hit;

   // Fetch path
   logic [ADDR_W-1:0]  rd_addr;
   logic [7:0]         len8;
   logic [7:0]         pl8;
   logic [7:0]         pl_crc;
   logic [COUNT_W-1:0] remain;
   logic               last_group;
   logic [2:0]         group_size;
   logic               group_done;

   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   // Running group checksum and SSID checksum for the next byte
   assign full      = (count_ff == COUNT_W'(MAX_BYTES));
   assign pos       = count_ff[ADDR_W-1:0];
   assign app_group = pos[ADDR_W-1:2];
   assign seed      = (pos[1:0] == 2'd0) ? crc8_byte(8'(app_group)) : gc_run_ff;
   assign gc_new    = crc8_byte(seed ^ data_byte_ff);
   assign ssid_hit  = 8'(count_ff) > {1'b0, pass_len_ff};

   // Symbol fields
   assign rd_addr    = {group_ff, slot_ff[1:0] - 2'd2};
   assign len8       = 8'(count_ff);
   assign pl8        = {1'b0, pass_len_ff};
   assign pl_crc     = crc8_byte(pl8);
   assign remain     = count_ff - COUNT_W'({group_ff, 2'b00});
   assign last_group = (remain <= COUNT_W'(4));
   assign group_size = last_group ? remain[2:0] : 3'd4;
   assign group_done = (slot_ff >= group_size + 3'd1);

   // Next state of counters, checksums, pointer and response
   always_comb begin
      count_in         = count_ff;
      ssid_in          = ssid_ff;
      overflow_in      = overflow_ff;
      phase_in         = phase_ff;
      group_in         = group_ff;
      slot_in          = slot_ff;
      rsp_symbol_in    = 9'h000;
      rsp_frame_end_in = 1'b0;
      rsp_status_in    = overflow_ff ? STATUS_OVERFLOW : STATUS_OK;

      if (cmd.append) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + COUNT_W'(1);
            if (ssid_hit) begin
               ssid_in = crc8_byte(ssid_ff ^ data_byte_ff);
            end
         end
      end

      if (cmd.clear) begin
         count_in    = '0;
         ssid_in     = 8'h00;
         overflow_in = 1'b0;
         phase_in    = PHASE_MAGIC;
         group_in    = '0;
         slot_in     = 3'd0;
      end

      if (cmd.fetch) begin
         if (count_ff == '0) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            case (phase_ff)
               PHASE_MAGIC: begin
                  case (slot_ff)
                     3'd0: rsp_symbol_in = (len8[7:4] == 4'h0) ? 9'h008
                                                               : {5'h00, len8[7:4]};
                     3'd1: rsp_symbol_in = {5'h01, len8[3:0]};
                     3'd2: rsp_symbol_in = {5'h02, ssid_ff[7:4]};
                     default: rsp_symbol_in = {5'h03, ssid_ff[3:0]};
                  endcase
                  if (slot_ff >= 3'd3) begin
                     phase_in = PHASE_PREFIX;
                     slot_in  = 3'd0;
                  end else begin
                     slot_in = slot_ff + 3'd1;
                  end
               end
               PHASE_PREFIX: begin
                  case (slot_ff)
                     3'd0: rsp_symbol_in = {5'h04, pl8[7:4]};
                     3'd1: rsp_symbol_in = {5'h05, pl8[3:0]};
                     3'd2: rsp_symbol_in = {5'h06, pl_crc[7:4]};
                     default: rsp_symbol_in = {5'h07, pl_crc[3:0]};
                  endcase
                  if (slot_ff >= 3'd3) begin
                     phase_in = PHASE_GROUPS;
                     group_in = '0;
                     slot_in  = 3'd0;
                  end else begin
                     slot_in = slot_ff + 3'd1;
                  end
               end
               PHASE_GROUPS: begin
                  case (slot_ff)
                     3'd0: rsp_symbol_in = 9'h080 | {1'b0, gc_rd_ff};
                     3'd1: rsp_symbol_in = 9'h080 | 9'(group_ff);
                     default: rsp_symbol_in = 9'h100 | {1'b0, byte_rd_ff};
                  endcase
                  if (group_done) begin
                     if (last_group) begin
                        rsp_frame_end_in = 1'b1;
                        phase_in         = PHASE_MAGIC;
                        group_in         = '0;
                     end else begin
                        group_in = group_ff + GROUP_W'(1);
                     end
                     slot_in = 3'd0;
                  end else begin
                     slot_in = slot_ff + 3'd1;
                  end
               end
               default: begin
                  phase_in = PHASE_MAGIC;
                  group_in = '0;
                  slot_in  = 3'd0;
               end
            endcase
         end
      end
   end

   // Write stores on append; read at the frame pointer every cycle
   always_ff @(posedge clock) begin
      if (cmd.append && !full) begin
         byte_mem[pos]      <= data_byte_ff;
         gc_mem[app_group]  <= gc_new;
      end
      byte_rd_ff <= byte_mem[rd_addr];
      gc_rd_ff   <= gc_mem[group_ff];
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         data_byte_ff <= req_data_byte;
      end
      if (cmd.append && !full) begin
         gc_run_ff <= gc_new;
      end
      if (cmd.fetch) begin
         rsp_symbol_ff    <= rsp_symbol_in;
         rsp_frame_end_ff <= rsp_frame_end_in;
         rsp_status_ff    <= rsp_status_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ssid_ff      <= 8'h00;
         overflow_ff  <= 1'b0;
         phase_ff     <= PHASE_MAGIC;
         group_ff     <= '0;
         slot_ff      <= 3'd0;
         pass_len_ff  <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         ssid_ff     <= ssid_in;
         overflow_ff <= overflow_in;
         phase_ff    <= phase_in;
         group_ff    <= group_in;
         slot_ff     <= slot_in;
         if (csr_wr_en) begin
            pass_len_ff <= csr_wr_data;
         end
         if (cmd.fetch) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_symbol    = rsp_symbol_ff;
   assign rsp_frame_end = rsp_frame_end_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* rtl/core/wifi_credential_length_encoder.sv */
// Top level of the credential packet-length symbol encoder.
// Append and clear: executed in the cycle after acceptance, then ready again.
// Fetch: symbol registered from the registered byte and checksum store reads once
// the response register is free; the request side stays busy until then.
// Unused function code: taken without an execute state, no response.
// Reset (synchronous, active high) clears the count, SSID checksum, frame pointer and
// password length; the byte and group checksum stores are not cleared.
module wifi_credential_length_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [8:0] rsp_symbol,
   output logic       rsp_frame_end,
   output logic [1:0] rsp_status,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import wcle_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   wcle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .stat      (stat),
      .cmd       (cmd)
   );

   wcle_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_data_byte (req_data_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_symbol    (rsp_symbol),
      .rsp_frame_end (rsp_frame_end),
      .rsp_status    (rsp_status)
   );

endmodule

/* rtl/core/wcle_checker.sv */
// Port-level assertions for the encoder, bound to the top level.
module wcle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_func,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [8:0] rsp_symbol,
   input logic       rsp_frame_end,
   input logic [1:0] rsp_status
);
   import wcle_pkg::*;

   // A stalled response holds its symbol
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol))
      else $error("stalled response changed");

   // An empty-buffer response carries symbol zero and no frame end
   a_empty_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> (rsp_symbol == 9'h000) && !rsp_frame_end)
      else $error("empty response carries data");

   // A frame end never comes from an empty buffer
   a_end_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> (rsp_status != STATUS_EMPTY))
      else $error("frame end on empty buffer");

   // A working transaction keeps the request side busy for its execute cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_APPEND || req_func == FUNC_FETCH
         || req_func == FUNC_CLEAR) |=> !req_ready)
      else $error("request accepted during execute cycle");

endmodule

bind wifi_credential_length_encoder wcle_checker u_wcle_checker (.*);
